// File: sv/double_ended_queue_core_assert.svh
// assertion macros shared by the deque checker
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// same-cycle implication, quiet during reset
`define DEQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deque check failed");

// next-cycle implication, quiet during reset
`define DEQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deque check failed");

`endif

// File: sv/deq_pkg.sv
package deq_pkg;

   // operation codes
   localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [2:0] KIND_PUSH_REAR  = 3'd1;
   localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [2:0] KIND_POP_REAR   = 3'd3;
   localparam logic [2:0] KIND_PEEK_FRONT = 3'd4;
   localparam logic [2:0] KIND_PEEK_REAR  = 3'd5;

   // result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // one customer record, arrival in the low bits
   typedef struct packed {
      logic [15:0] end_time;
      logic [15:0] start_time;
      logic [15:0] service_time;
      logic [15:0] arrival_time;
   } record_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic shift_a_up;
      logic shift_a_down;
      logic shift_b_up;
      logic shift_b_down;
      logic write_a_tail;
      logic write_b_tail;
   } cell_ctrl_type;

endpackage

// File: sv/deq_cell.sv
module deq_cell #(
   parameter int unsigned INDEX = 0,
   parameter int unsigned CNT_W = 5
) (
   input  logic                   clock,
   input  deq_pkg::cell_ctrl_type ctrl,
   input  logic [CNT_W-1:0]       count,
   input  deq_pkg::record_type    rec,
   input  deq_pkg::record_type    a_left,
   input  deq_pkg::record_type    a_right,
   input  deq_pkg::record_type    b_left,
   input  deq_pkg::record_type    b_right,
   output deq_pkg::record_type    a_out,
   output deq_pkg::record_type    b_out
);

   deq_pkg::record_type a_data_ff, a_data_in;
   deq_pkg::record_type b_data_ff, b_data_in;
   logic                tail;

   // this cell is the first free slot of both chains
   assign tail = (count == CNT_W'(INDEX));

   // front-ordered chain
   always_comb begin
      a_data_in = a_data_ff;
      if (ctrl.shift_a_up) begin
         a_data_in = a_left;
      end else if (ctrl.shift_a_down) begin
         a_data_in = a_right;
      end else if (ctrl.write_a_tail && tail) begin
         a_data_in = rec;
      end
   end

   // rear-ordered chain
   always_comb begin
      b_data_in = b_data_ff;
      if (ctrl.shift_b_up) begin
         b_data_in = b_left;
      end else if (ctrl.shift_b_down) begin
         b_data_in = b_right;
      end else if (ctrl.write_b_tail && tail) begin
         b_data_in = rec;
      end
   end

   always_ff @(posedge clock) begin
      a_data_ff <= a_data_in;
      b_data_ff <= b_data_in;
   end

   assign a_out = a_data_ff;
   assign b_out = b_data_ff;

endmodule

// File: sv/double_ended_queue_core.sv
// result: strobes in the cycle after its transfer is taken
// throughput: one operation every cycle, busy never rises; a push or pop that
// succeeds shifts or writes the cell row, other operations leave it alone
// reset: synchronous, clears the count and the result strobe; cell contents
// are left as they are and are never read before being written
module double_ended_queue_core #(
   parameter int unsigned DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [2:0]                   req_kind,
   input  logic [15:0]                  req_arrival_time,
   input  logic [15:0]                  req_service_time,
   input  logic [15:0]                  req_start_time,
   input  logic [15:0]                  req_end_time,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_status,
   output logic [15:0]                  rsp_out_arrival,
   output logic [15:0]                  rsp_out_service,
   output logic [15:0]                  rsp_out_start,
   output logic [15:0]                  rsp_out_end,
   output logic [$clog2(DEPTH+1)-1:0]   rsp_occupancy,
   output logic                         rsp_is_empty
);

   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   deq_pkg::record_type    rec;
   deq_pkg::record_type    a_q [DEPTH];
   deq_pkg::record_type    b_q [DEPTH];
   deq_pkg::cell_ctrl_type ctrl;
   deq_pkg::record_type    got;
   logic [1:0]             status;
   logic                   accept;
   logic                   full;
   logic                   empty;

   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   rsp_valid_ff;
   logic [1:0]             rsp_status_ff;
   deq_pkg::record_type    rsp_rec_ff;
   logic [CNT_W-1:0]       rsp_occupancy_ff;
   logic                   rsp_is_empty_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);

   assign rec.arrival_time = req_arrival_time;
   assign rec.service_time = req_service_time;
   assign rec.start_time   = req_start_time;
   assign rec.end_time     = req_end_time;

   // operation decode: front record sits in a_q[0], rear record in b_q[0]
   always_comb begin
      ctrl     = '0;
      got      = '0;
      status   = deq_pkg::STATUS_OK;
      count_in = count_ff;
      if (accept) begin
         unique case (req_kind)
            deq_pkg::KIND_PUSH_FRONT: begin
               if (full) begin
                  status = deq_pkg::STATUS_FULL;
               end else begin
                  ctrl.shift_a_up   = 1'b1;
                  ctrl.write_b_tail = 1'b1;
                  count_in          = count_ff + CNT_W'(1);
               end
            end
            deq_pkg::KIND_PUSH_REAR: begin
               if (full) begin
                  status = deq_pkg::STATUS_FULL;
               end else begin
                  ctrl.shift_b_up   = 1'b1;
                  ctrl.write_a_tail = 1'b1;
                  count_in          = count_ff + CNT_W'(1);
               end
            end
            deq_pkg::KIND_POP_FRONT: begin
               if (empty) begin
                  status = deq_pkg::STATUS_EMPTY;
               end else begin
                  got               = a_q[0];
                  ctrl.shift_a_down = 1'b1;
                  count_in          = count_ff - CNT_W'(1);
               end
            end
            deq_pkg::KIND_POP_REAR: begin
               if (empty) begin
                  status = deq_pkg::STATUS_EMPTY;
               end else begin
                  got               = b_q[0];
                  ctrl.shift_b_down = 1'b1;
                  count_in          = count_ff - CNT_W'(1);
               end
            end
            deq_pkg::KIND_PEEK_FRONT: begin
               if (empty) begin
                  status = deq_pkg::STATUS_EMPTY;
               end else begin
                  got = a_q[0];
               end
            end
            deq_pkg::KIND_PEEK_REAR: begin
               if (empty) begin
                  status = deq_pkg::STATUS_EMPTY;
               end else begin
                  got = b_q[0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // row of cells, each wired to its two neighbors
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      deq_pkg::record_type a_left, a_right, b_left, b_right;

      if (i == 0) begin : g_first
         assign a_left = rec;
         assign b_left = rec;
      end else begin : g_inner_left
         assign a_left = a_q[i-1];
         assign b_left = b_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign a_right = a_q[i];
         assign b_right = b_q[i];
      end else begin : g_inner_right
         assign a_right = a_q[i+1];
         assign b_right = b_q[i+1];
      end

      deq_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock   (clock),
         .ctrl    (ctrl),
         .count   (count_ff),
         .rec     (rec),
         .a_left  (a_left),
         .a_right (a_right),
         .b_left  (b_left),
         .b_right (b_right),
         .a_out   (a_q[i]),
         .b_out   (b_q[i])
      );
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff    <= status;
         rsp_rec_ff       <= got;
         rsp_occupancy_ff <= count_in;
         rsp_is_empty_ff  <= (count_in == '0);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_arrival = rsp_rec_ff.arrival_time;
   assign rsp_out_service = rsp_rec_ff.service_time;
   assign rsp_out_start   = rsp_rec_ff.start_time;
   assign rsp_out_end     = rsp_rec_ff.end_time;
   assign rsp_occupancy   = rsp_occupancy_ff;
   assign rsp_is_empty    = rsp_is_empty_ff;

endmodule

// File: sv/deq_checker.sv
`include "double_ended_queue_core_assert.svh"

module deq_checker #(
   parameter int unsigned DEPTH = 16
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_valid,
   input logic [1:0]                 rsp_status,
   input logic [15:0]                rsp_out_arrival,
   input logic [15:0]                rsp_out_service,
   input logic [15:0]                rsp_out_start,
   input logic [15:0]                rsp_out_end,
   input logic [$clog2(DEPTH+1)-1:0] rsp_occupancy,
   input logic                       rsp_is_empty
);

   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   // every transfer gives a result in the next cycle
   `DEQ_ASSERT_NEXT(a_result_follows, start && !busy, rsp_valid)

   // no result without a transfer in the cycle before
   `DEQ_ASSERT_NOW(a_no_stray_result, rsp_valid, $past(start && !busy))

   // rejected push leaves the deque full and carries no record
   `DEQ_ASSERT_NOW(a_full_reject, rsp_valid && rsp_status == deq_pkg::STATUS_FULL,
      rsp_occupancy == CNT_W'(DEPTH) && rsp_out_arrival == 16'd0 &&
      rsp_out_service == 16'd0 && rsp_out_start == 16'd0 && rsp_out_end == 16'd0)

   // empty status agrees with count and flag
   `DEQ_ASSERT_NOW(a_empty_status, rsp_valid && rsp_status == deq_pkg::STATUS_EMPTY,
      rsp_occupancy == '0 && rsp_is_empty)

endmodule

bind double_ended_queue_core deq_checker #(
   .DEPTH (DEPTH)
) u_deq_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_out_arrival (rsp_out_arrival),
   .rsp_out_service (rsp_out_service),
   .rsp_out_start   (rsp_out_start),
   .rsp_out_end     (rsp_out_end),
   .rsp_occupancy   (rsp_occupancy),
   .rsp_is_empty    (rsp_is_empty)
);

// File: tb/tb_double_ended_queue_core.sv
module tb_double_ended_queue_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DEPTH        = 16;
   localparam int unsigned RANDOM_ITEMS = 750;
   localparam int unsigned CYCLE_LIMIT  = 300000;
   localparam int unsigned DRAIN_CYCLES = 4;

   // kinds the block ignores
   localparam logic [2:0] KIND_RESERVED_A = 3'd6;
   localparam logic [2:0] KIND_RESERVED_B = 3'd7;

   // one expected result transfer
   typedef struct {
      logic [1:0]          status;
      deq_pkg::record_type rec;
      logic [4:0]          occupancy;
      logic                is_empty;
   } deque_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_kind = deq_pkg::KIND_PUSH_FRONT;
   logic [15:0] req_arrival_time = '0;
   logic [15:0] req_service_time = '0;
   logic [15:0] req_start_time = '0;
   logic [15:0] req_end_time = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_out_arrival;
   logic [15:0] rsp_out_service;
   logic [15:0] rsp_out_start;
   logic [15:0] rsp_out_end;
   logic [4:0]  rsp_occupancy;
   logic        rsp_is_empty;

   // shadow deque
   deq_pkg::record_type shadow_ring [DEPTH];
   int unsigned front_ptr = 0;
   int unsigned rear_ptr = 0;
   int unsigned stored_count = 0;

   deque_reply_type pending_replies [$];
   deque_reply_type want_reply;
   int unsigned     error_count = 0;
   int unsigned     cycle_count = 0;

   double_ended_queue_core #(
      .DEPTH(DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_kind(req_kind),
      .req_arrival_time(req_arrival_time),
      .req_service_time(req_service_time),
      .req_start_time(req_start_time),
      .req_end_time(req_end_time),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_out_arrival(rsp_out_arrival),
      .rsp_out_service(rsp_out_service),
      .rsp_out_start(rsp_out_start),
      .rsp_out_end(rsp_out_end),
      .rsp_occupancy(rsp_occupancy),
      .rsp_is_empty(rsp_is_empty)
   );

   // clock
   always #10 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic int unsigned ring_next(input int unsigned idx);
      return (idx + 1 >= DEPTH) ? 0 : idx + 1;
   endfunction

   function automatic int unsigned ring_prev(input int unsigned idx);
      return (idx == 0) ? DEPTH - 1 : idx - 1;
   endfunction

   // apply one operation to the shadow deque and queue its reply
   task automatic apply_deque_op(input logic [2:0] kind, input deq_pkg::record_type rec);
      deque_reply_type reply;
      reply.status = deq_pkg::STATUS_OK;
      reply.rec    = '0;
      case (kind)
         deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_REAR: begin
            if (stored_count >= DEPTH) begin
               reply.status = deq_pkg::STATUS_FULL;
            end else if (kind == deq_pkg::KIND_PUSH_FRONT) begin
               front_ptr = ring_prev(front_ptr);
               shadow_ring[front_ptr] = rec;
               stored_count++;
            end else begin
               shadow_ring[rear_ptr] = rec;
               rear_ptr = ring_next(rear_ptr);
               stored_count++;
            end
         end
         deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_REAR: begin
            if (stored_count == 0) begin
               reply.status = deq_pkg::STATUS_EMPTY;
            end else if (kind == deq_pkg::KIND_POP_FRONT) begin
               reply.rec = shadow_ring[front_ptr];
               front_ptr = ring_next(front_ptr);
               stored_count--;
            end else begin
               rear_ptr = ring_prev(rear_ptr);
               reply.rec = shadow_ring[rear_ptr];
               stored_count--;
            end
         end
         deq_pkg::KIND_PEEK_FRONT, deq_pkg::KIND_PEEK_REAR: begin
            if (stored_count == 0)
               reply.status = deq_pkg::STATUS_EMPTY;
            else if (kind == deq_pkg::KIND_PEEK_FRONT)
               reply.rec = shadow_ring[front_ptr];
            else
               reply.rec = shadow_ring[ring_prev(rear_ptr)];
         end
         default: begin
         end
      endcase
      reply.occupancy = stored_count[4:0];
      reply.is_empty  = (stored_count == 0);
      pending_replies.push_back(reply);
   endtask

   task automatic check_field(input string name, input logic [15:0] want_v,
                              input logic [15:0] got_v);
      if (got_v !== want_v) begin
         $error("%s expected %0h got %0h", name, want_v, got_v);
         error_count++;
      end
   endtask

   // compare each result transfer with the oldest expected reply
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_replies.size() == 0) begin
            $error("result transfer with no expected reply");
            error_count++;
         end else begin
            want_reply = pending_replies.pop_front();
            check_field("status", 16'(want_reply.status), 16'(rsp_status));
            check_field("out_arrival", want_reply.rec.arrival_time, rsp_out_arrival);
            check_field("out_service", want_reply.rec.service_time, rsp_out_service);
            check_field("out_start", want_reply.rec.start_time, rsp_out_start);
            check_field("out_end", want_reply.rec.end_time, rsp_out_end);
            check_field("occupancy", 16'(want_reply.occupancy), 16'(rsp_occupancy));
            check_field("is_empty", 16'(want_reply.is_empty), 16'(rsp_is_empty));
         end
      end
   end

   // drive one command and wait for its transfer; start stays high
   task automatic send_op(input logic [2:0] kind, input deq_pkg::record_type rec);
      start            <= 1'b1;
      req_kind         <= kind;
      req_arrival_time <= rec.arrival_time;
      req_service_time <= rec.service_time;
      req_start_time   <= rec.start_time;
      req_end_time     <= rec.end_time;
      @(posedge clock);
      while (busy) @(posedge clock);
      apply_deque_op(kind, rec);
   endtask

   task automatic idle_gap(input int unsigned cycles);
      if (cycles != 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // hold off the sender until every reply is back
   task automatic wait_for_replies();
      start <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_time();
      logic [15:0] value;
      value = 16'($urandom);
      case ($urandom_range(7))
         0: value = 16'h0000;
         1: value = 16'hFFFF;
         default: begin
         end
      endcase
      return value;
   endfunction

   function automatic deq_pkg::record_type random_record();
      deq_pkg::record_type rec;
      rec.arrival_time = pick_time();
      rec.service_time = pick_time();
      rec.start_time   = pick_time();
      rec.end_time     = pick_time();
      return rec;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 60)
         return 0;
      else if (roll < 90)
         return $urandom_range(3, 1);
      else
         return $urandom_range(40, 8);
   endfunction

   // pop and peek at both ends of an empty deque
   task automatic test_empty_deque();
      send_op(deq_pkg::KIND_POP_FRONT, random_record());
      send_op(deq_pkg::KIND_POP_REAR, random_record());
      idle_gap(1);
      send_op(deq_pkg::KIND_PEEK_FRONT, random_record());
      send_op(deq_pkg::KIND_PEEK_REAR, random_record());
   endtask

   // unused kinds leave the state alone
   task automatic test_reserved_kinds();
      send_op(KIND_RESERVED_A, random_record());
      send_op(KIND_RESERVED_B, random_record());
   endtask

   // fill from both ends, edge-value records first, then push into a full deque
   task automatic test_fill_and_reject();
      deq_pkg::record_type rec;
      for (int unsigned i = 0; i < DEPTH; i++) begin
         case (i)
            0: rec = '1;
            1: rec = '0;
            2: rec = {4{16'hAAAA}};
            3: rec = {4{16'h5555}};
            default: rec = random_record();
         endcase
         send_op((i % 2 == 0) ? deq_pkg::KIND_PUSH_FRONT : deq_pkg::KIND_PUSH_REAR, rec);
         if (i == 7)
            idle_gap(2);
      end
      send_op(deq_pkg::KIND_PUSH_FRONT, '1);
      send_op(deq_pkg::KIND_PUSH_REAR, random_record());
   endtask

   // look at both ends of the full deque
   task automatic test_peek_ends();
      send_op(deq_pkg::KIND_PEEK_FRONT, random_record());
      send_op(deq_pkg::KIND_PEEK_REAR, random_record());
      wait_for_replies();
   endtask

   // biased phases drive the deque between empty and full
   task automatic test_random_traffic();
      int unsigned sent;
      int unsigned phase_left;
      int unsigned push_pct;
      bit          burst;
      logic [2:0]  kind;
      sent       = 0;
      phase_left = 0;
      push_pct   = 50;
      burst      = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         if (phase_left == 0) begin
            case ($urandom_range(3))
               0: push_pct = 85;
               1: push_pct = 15;
               2: push_pct = 60;
               default: push_pct = 40;
            endcase
            burst      = ($urandom_range(3) == 0);
            phase_left = $urandom_range(60, 20);
            if ($urandom_range(2) == 0)
               wait_for_replies();
         end
         if ($urandom_range(99) < 2) begin
            kind = $urandom_range(1) ? KIND_RESERVED_A : KIND_RESERVED_B;
         end else if ($urandom_range(99) < push_pct) begin
            kind = $urandom_range(1) ? deq_pkg::KIND_PUSH_FRONT : deq_pkg::KIND_PUSH_REAR;
         end else begin
            case ($urandom_range(5))
               0, 1: kind = deq_pkg::KIND_POP_FRONT;
               2, 3: kind = deq_pkg::KIND_POP_REAR;
               4: kind = deq_pkg::KIND_PEEK_FRONT;
               default: kind = deq_pkg::KIND_PEEK_REAR;
            endcase
         end
         send_op(kind, random_record());
         if (kind != KIND_RESERVED_A && kind != KIND_RESERVED_B) begin
            sent++;
            phase_left--;
         end
         if (!burst)
            idle_gap(pick_gap());
      end
   endtask

   // test sequence
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_empty_deque();
      test_reserved_kinds();
      test_fill_and_reject();
      test_peek_ends();
      test_random_traffic();
      wait_for_replies();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
